>>> design/aal_pkg.sv
// Shared constants, command/status bundles and result layout for the shelf atlas allocator.
package aal_pkg;

  localparam int PAGE_SIZE_DEF   = 1024;
  localparam int MAX_PAGES_DEF   = 8;
  localparam int SHELVES_DEF     = 64;

  localparam int RECT_W          = 11;
  localparam int LIMIT_W         = 4;
  localparam int LIMIT_RESET     = 8;
  localparam int IN_DATA_W       = 24;
  localparam int OUT_DATA_W      = 32;

  localparam logic ACT_PLACE     = 1'b0;
  localparam logic ACT_CLEAR     = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;        // capture the incoming request
    logic clear;       // empty all pages, post a clear result
    logic fail;        // post a failed result
    logic start;       // restart the page scan at page zero
    logic page_rd;     // read the page table at the current page
    logic page_load;   // take shelf count and fill height from the page read
    logic page_next;   // advance to the next page
    logic shelf_rd;    // read the current shelf
    logic shelf_next;  // advance to the next shelf
    logic put_shelf;   // place on the shelf just read
    logic open_shelf;  // open a new shelf below the used height
    logic open_page;   // open a new page
  } aal_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic is_clear;
    logic reject;
    logic pages_left;
    logic page_room;
    logic shelves_left;
    logic shelf_fits;
    logic shelf_room;
    logic out_free;
  } aal_stat_t;

  // Result item, first field in the highest bits
  typedef struct packed {
    logic [9:0] pos_y;
    logic [9:0] pos_x;
    logic [2:0] page_index;
    logic       opened_page;
    logic       ok;
  } aal_res_t;

endpackage

>>> design/aal_ctrl.sv
// Sequencing state machine for the shelf atlas allocator.
module aal_ctrl
  import aal_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  aal_stat_t stat,
  output aal_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_DECIDE    = 6'b000010,
    ST_PAGE      = 6'b000100,
    ST_PAGE_WAIT = 6'b001000,
    ST_SCAN      = 6'b010000,
    ST_SH_CHK    = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   term;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_clear) begin
          if (stat.out_free) begin
            cmd.clear  = 1'b1;
            state_next = ST_IDLE;
          end
        end else if (stat.reject) begin
          if (stat.out_free) begin
            cmd.fail   = 1'b1;
            state_next = ST_IDLE;
          end
        end else begin
          cmd.start  = 1'b1;
          state_next = ST_PAGE;
        end
      end
      ST_PAGE: begin
        if (stat.pages_left) begin
          cmd.page_rd = 1'b1;
          state_next  = ST_PAGE_WAIT;
        end else if (stat.out_free) begin
          cmd.open_page = stat.page_room;
          cmd.fail      = !stat.page_room;
          state_next    = ST_IDLE;
        end
      end
      ST_PAGE_WAIT: begin
        cmd.page_load = 1'b1;
        state_next    = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat.shelves_left) begin
          cmd.shelf_rd = 1'b1;
          state_next   = ST_SH_CHK;
        end else if (stat.shelf_room) begin
          if (stat.out_free) begin
            cmd.open_shelf = 1'b1;
            state_next     = ST_IDLE;
          end
        end else begin
          cmd.page_next = 1'b1;
          state_next    = ST_PAGE;
        end
      end
      ST_SH_CHK: begin
        if (stat.shelf_fits) begin
          if (stat.out_free) begin
            cmd.put_shelf = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          cmd.shelf_next = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign term = cmd.clear | cmd.fail | cmd.put_shelf | cmd.open_shelf | cmd.open_page;

  a_one_result: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear, cmd.fail, cmd.put_shelf, cmd.open_shelf, cmd.open_page}))
    else $error("more than one result posted in a cycle");

  a_result_slot: assert property (@(posedge clk) disable iff (rst)
    term |-> stat.out_free)
    else $error("result posted while the output register is occupied");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    term |=> (state == ST_IDLE))
    else $error("controller did not return to idle after a result");

endmodule

>>> design/aal_dp.sv
// Page table, shelf memory, comparators and result register of the shelf atlas allocator.
module aal_dp
  import aal_pkg::*;
#(
  parameter int PAGE_SIZE        = PAGE_SIZE_DEF,
  parameter int MAX_PAGES        = MAX_PAGES_DEF,
  parameter int SHELVES_PER_PAGE = SHELVES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  aal_cmd_t           cmd,
  output aal_stat_t          stat,
  input  logic               in_action,
  input  logic [RECT_W-1:0]  in_width,
  input  logic [RECT_W-1:0]  in_height,
  input  logic               cfg_wr_en,
  input  logic [LIMIT_W-1:0] cfg_wr_data,
  output logic               out_valid,
  input  logic               out_ready,
  output aal_res_t           out_res
);

  localparam int DW    = $clog2(PAGE_SIZE + 1);
  localparam int PW    = $clog2(PAGE_SIZE);
  localparam int CW    = $clog2(SHELVES_PER_PAGE + 1);
  localparam int NSH   = MAX_PAGES * SHELVES_PER_PAGE;
  localparam int AW    = (NSH > 1) ? $clog2(NSH) : 1;
  localparam int ABW   = $clog2(NSH + 1);
  localparam int PGW   = $clog2(MAX_PAGES + 1);
  localparam int PIW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  typedef struct packed {
    logic [PW-1:0] top;
    logic [DW-1:0] tall;
    logic [DW-1:0] fill;
  } shelf_t;

  typedef struct packed {
    logic [DW-1:0] fill;
    logic [CW-1:0] cnt;
  } page_t;

  // Request and configuration
  logic               action;
  logic [RECT_W-1:0]  rect_w;
  logic [RECT_W-1:0]  rect_h;
  logic [LIMIT_W-1:0] page_limit;
  logic [PGW-1:0]     open_pages;

  // Scan position
  logic [PGW-1:0]     pg;
  logic [ABW-1:0]     base;
  logic [CW-1:0]      shelf_idx;
  logic [CW-1:0]      count;
  logic [DW-1:0]      fill_h;

  // Memories
  shelf_t             smem [NSH];
  page_t              pmem [MAX_PAGES];
  shelf_t             sq;
  page_t              pq;

  logic [DW-1:0]      w_d;
  logic [DW-1:0]      h_d;
  logic [DW-1:0]      room_w;
  logic [DW-1:0]      room_h;
  logic [AW-1:0]      base_a;
  logic [AW-1:0]      sh_raddr;
  logic [AW-1:0]      sh_waddr;
  shelf_t             sh_wdata;
  logic               sh_we;
  page_t              pg_wdata;
  logic               pg_we;
  logic               term;
  aal_res_t           res_next;

  assign w_d    = DW'(rect_w);
  assign h_d    = DW'(rect_h);
  assign room_w = DW'(PAGE_SIZE) - w_d;
  assign room_h = DW'(PAGE_SIZE) - h_d;
  assign base_a = AW'(base);

  assign stat.is_clear     = (action == ACT_CLEAR);
  assign stat.reject       = (rect_w == '0) || (rect_h == '0) ||
                             (32'(rect_w) > 32'(PAGE_SIZE)) ||
                             (32'(rect_h) > 32'(PAGE_SIZE));
  assign stat.pages_left   = (pg < open_pages);
  assign stat.page_room    = (32'(open_pages) < 32'(MAX_PAGES)) &&
                             (32'(open_pages) < 32'(page_limit));
  assign stat.shelves_left = (shelf_idx < count);
  assign stat.shelf_fits   = (h_d <= sq.tall) && (sq.fill <= room_w);
  assign stat.shelf_room   = (32'(count) < 32'(SHELVES_PER_PAGE)) && (fill_h <= room_h);
  assign stat.out_free     = !out_valid || out_ready;

  assign sh_raddr = base_a + AW'(shelf_idx);

  // Shelf write port: one writer command per cycle
  always_comb begin
    sh_we    = 1'b0;
    sh_waddr = base_a;
    sh_wdata = '{top: '0, tall: h_d, fill: w_d};
    pg_we    = 1'b0;
    pg_wdata = '{fill: h_d, cnt: CW'(1)};
    if (cmd.put_shelf) begin
      sh_we    = 1'b1;
      sh_waddr = sh_raddr;
      sh_wdata = '{top: sq.top, tall: sq.tall, fill: sq.fill + w_d};
    end else if (cmd.open_shelf) begin
      sh_we    = 1'b1;
      sh_waddr = base_a + AW'(count);
      sh_wdata = '{top: PW'(fill_h), tall: h_d, fill: w_d};
      pg_we    = 1'b1;
      pg_wdata = '{fill: fill_h + h_d, cnt: count + CW'(1)};
    end else if (cmd.open_page) begin
      sh_we    = 1'b1;
      pg_we    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (sh_we) begin
      smem[sh_waddr] <= sh_wdata;
    end
    if (cmd.shelf_rd) begin
      sq <= smem[sh_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (pg_we) begin
      pmem[pg[PIW-1:0]] <= pg_wdata;
    end
    if (cmd.page_rd) begin
      pq <= pmem[pg[PIW-1:0]];
    end
  end

  // Request capture and scan position
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action <= in_action;
      rect_w <= in_width;
      rect_h <= in_height;
    end
    if (cmd.start) begin
      pg   <= '0;
      base <= '0;
    end else if (cmd.page_next) begin
      pg   <= pg + PGW'(1);
      base <= base + ABW'(SHELVES_PER_PAGE);
    end
    if (cmd.page_load) begin
      count     <= pq.cnt;
      fill_h    <= pq.fill;
      shelf_idx <= '0;
    end else if (cmd.shelf_next) begin
      shelf_idx <= shelf_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_limit <= LIMIT_W'(LIMIT_RESET);
      open_pages <= '0;
    end else begin
      if (cfg_wr_en) begin
        page_limit <= cfg_wr_data;
      end
      if (cmd.clear) begin
        open_pages <= '0;
      end else if (cmd.open_page) begin
        open_pages <= open_pages + PGW'(1);
      end
    end
  end

  // Result register
  assign term = cmd.clear | cmd.fail | cmd.put_shelf | cmd.open_shelf | cmd.open_page;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (term) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_comb begin
    res_next = '0;
    if (cmd.clear) begin
      res_next.ok = 1'b1;
    end else if (cmd.put_shelf) begin
      res_next.ok         = 1'b1;
      res_next.page_index = 3'(pg);
      res_next.pos_x      = 10'(sq.fill);
      res_next.pos_y      = 10'(sq.top);
    end else if (cmd.open_shelf) begin
      res_next.ok         = 1'b1;
      res_next.page_index = 3'(pg);
      res_next.pos_y      = 10'(fill_h);
    end else if (cmd.open_page) begin
      res_next.ok          = 1'b1;
      res_next.opened_page = 1'b1;
      res_next.page_index  = 3'(pg);
    end
  end

  always_ff @(posedge clk) begin
    if (term) begin
      out_res <= res_next;
    end
  end

  a_pages_bound: assert property (@(posedge clk) disable iff (rst)
    32'(open_pages) <= 32'(MAX_PAGES))
    else $error("open page count beyond the page table");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.page_load |=> (32'(count) <= 32'(SHELVES_PER_PAGE)))
    else $error("page shelf count beyond the shelf table");

endmodule

>>> design/shelf_atlas_allocator_core.sv
// Top level of the shelf atlas allocator: stream ports, controller and datapath.
//
// Use: a request arrives on the s_axis channel. tuser carries the action
// (0 place a rectangle, 1 clear all pages); tdata carries the rectangle width
// and height. Every transaction produces exactly one result transaction on
// m_axis: ok, opened_page, page index and the top-left corner of the placement.
// page_limit must be written through cfg_wr_en / cfg_wr_data only while the block idles;
// the block itself does not enforce this.
// Timing: one request is worked at a time. A clear or a rejected request
// posts its result straight from the decision state. A placement walks the
// open pages in order; each page costs a table read, a load and a final check,
// and each shelf read on it a read of the shelf memory plus a compare.
// s_axis_tready rises again in the same cycle that the result appears on m_axis.
//
// Reset (rst, synchronous) empties all pages and sets page_limit to 8; the
// shelf and page tables need no clearing, as only opened pages are read.
// When the receiver stalls, the result waits in the output register and the
// next request is still taken; its result waits until that register frees.
module shelf_atlas_allocator_core
  import aal_pkg::*;
#(
  parameter int PAGE_SIZE        = PAGE_SIZE_DEF,
  parameter int MAX_PAGES        = MAX_PAGES_DEF,
  parameter int SHELVES_PER_PAGE = SHELVES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request channel
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // rect_width[10:0], rect_height[21:11]
  input  logic [0:0]            s_axis_tuser,   // action[0]
  // Result channel
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // ok[0], opened_page[1], page_index[4:2],
                                                // pos_x[14:5], pos_y[24:15]
  // Configuration
  input  logic                  cfg_wr_en,
  input  logic [LIMIT_W-1:0]    cfg_wr_data
);

  aal_cmd_t  cmd;
  aal_stat_t stat;
  aal_res_t  res;

  // Sequencer: decides page/shelf walk, issues one command set per cycle
  aal_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Tables, comparators and the output register
  aal_dp #(
    .PAGE_SIZE        (PAGE_SIZE),
    .MAX_PAGES        (MAX_PAGES),
    .SHELVES_PER_PAGE (SHELVES_PER_PAGE)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_action   (s_axis_tuser[0]),
    .in_width    (s_axis_tdata[RECT_W-1:0]),
    .in_height   (s_axis_tdata[2*RECT_W-1:RECT_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_res     (res)
  );

  // Zero-fill the result to whole bytes
  assign m_axis_tdata = OUT_DATA_W'(res);

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for shelf_atlas_allocator_core: stream driver, monitor, shelf predictor.
module tb_top;
  import aal_pkg::*;

  // Worst placement: every shelf of every page scanned, plus a little slack.
  localparam int SETTLE     = 2 + 3 * MAX_PAGES_DEF + 2 * MAX_PAGES_DEF * SHELVES_DEF + 8;
  // Cycles with no transaction anywhere before the run is declared hung.
  localparam int HANG_LIMIT = 40 * SETTLE;
  localparam int PHASES     = 8;
  localparam int PHASE_REQS = 200;

  typedef struct {
    logic        act;
    logic [10:0] w;
    logic [10:0] h;
  } rect_req_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [0:0]            s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_wr_en = 1'b0;
  logic [LIMIT_W-1:0]    cfg_wr_data = '0;

  shelf_atlas_allocator_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  always #5 clk = ~clk;

  // Requests waiting to go out, and allocations the block still owes us.
  rect_req_t request_queue[$];
  aal_res_t  expected_allocs[$];

  // Percent chance per cycle that the sender idles / the receiver stalls.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned fault_count    = 0;
  int unsigned quiet_cycles   = 0;

  // Mirror of the packer state. Entries of unopened pages are never read.
  logic [LIMIT_W-1:0] limit_mirror = LIMIT_W'(LIMIT_RESET);
  int                 pages_in_use = 0;
  logic [10:0]        page_height  [MAX_PAGES_DEF];
  logic [6:0]         page_shelves [MAX_PAGES_DEF];
  logic [9:0]         shelf_y      [MAX_PAGES_DEF * SHELVES_DEF];
  logic [10:0]        shelf_height [MAX_PAGES_DEF * SHELVES_DEF];
  logic [10:0]        shelf_used_w [MAX_PAGES_DEF * SHELVES_DEF];

  rect_req_t driver_req;
  aal_res_t  want_alloc;
  aal_res_t  got_alloc;

  // Work out the allocation for one request and update the mirrored pages.
  function automatic aal_res_t predict_alloc(logic act, logic [10:0] w, logic [10:0] h);
    aal_res_t r;
    int p, s, k, cnt, cap;
    r = '0;
    if (act == ACT_CLEAR) begin
      pages_in_use = 0;
      r.ok = 1'b1;
      return r;
    end
    // Zero or oversize sides are rejected with an all-zero result.
    if (w == 0 || h == 0 || w > PAGE_SIZE_DEF || h > PAGE_SIZE_DEF) return r;
    for (p = 0; p < pages_in_use; p++) begin
      cnt = page_shelves[p];
      // First shelf tall enough with room on its right wins.
      for (s = 0; s < cnt; s++) begin
        k = p * SHELVES_DEF + s;
        if (h <= shelf_height[k] && int'(shelf_used_w[k]) + int'(w) <= PAGE_SIZE_DEF) begin
          r.ok         = 1'b1;
          r.page_index = p[2:0];
          r.pos_x      = shelf_used_w[k][9:0];
          r.pos_y      = shelf_y[k];
          shelf_used_w[k] = shelf_used_w[k] + w;
          return r;
        end
      end
      // Open a shelf below the used height unless the shelf table or the page height is full.
      if (cnt < SHELVES_DEF && int'(page_height[p]) + int'(h) <= PAGE_SIZE_DEF) begin
        k = p * SHELVES_DEF + cnt;
        shelf_y[k]      = page_height[p][9:0];
        shelf_height[k] = h;
        shelf_used_w[k] = w;
        page_shelves[p] = 7'(cnt + 1);
        page_height[p]  = page_height[p] + h;
        r.ok         = 1'b1;
        r.page_index = p[2:0];
        r.pos_y      = shelf_y[k];
        return r;
      end
    end
    // Out-of-range limits are capped; pages already open stay usable.
    cap = (int'(limit_mirror) > MAX_PAGES_DEF) ? MAX_PAGES_DEF : int'(limit_mirror);
    if (pages_in_use >= cap) return r;
    p = pages_in_use;
    k = p * SHELVES_DEF;
    shelf_y[k]      = '0;
    shelf_height[k] = h;
    shelf_used_w[k] = w;
    page_shelves[p] = 7'd1;
    page_height[p]  = h;
    pages_in_use    = p + 1;
    r.ok          = 1'b1;
    r.opened_page = 1'b1;
    r.page_index  = p[2:0];
    return r;
  endfunction

  task automatic check_field(string name, int want_v, int got_v);
    if (want_v != got_v) begin
      fault_count++;
      if (fault_count <= 10)
        $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want_v, got_v);
    end
  endtask

  // Driver: predict each accepted transaction, then load the next request.
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        expected_allocs.insert(expected_allocs.size(),
                               predict_alloc(s_axis_tuser[0], s_axis_tdata[10:0],
                                             s_axis_tdata[21:11]));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (request_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          driver_req = request_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {2'b00, driver_req.h, driver_req.w};
          s_axis_tuser  <= driver_req.act;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stall at random, compare each result with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_allocs.size() == 0) begin
          fault_count++;
          if (fault_count <= 10)
            $display("%0t: result with no request behind it, data %h", $realtime, m_axis_tdata);
        end else begin
          want_alloc = expected_allocs.pop_front();
          got_alloc  = aal_res_t'(m_axis_tdata[$bits(aal_res_t)-1:0]);
          check_field("ok", want_alloc.ok, got_alloc.ok);
          check_field("opened_page", want_alloc.opened_page, got_alloc.opened_page);
          check_field("page_index", want_alloc.page_index, got_alloc.page_index);
          check_field("pos_x", want_alloc.pos_x, got_alloc.pos_x);
          check_field("pos_y", want_alloc.pos_y, got_alloc.pos_y);
        end
      end
    end
  end

  // Watchdog: count cycles with no transaction on either channel and no config write.
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $realtime, HANG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic push_req(logic act, int w, int h);
    rect_req_t t;
    t.act = act;
    t.w   = 11'(w);
    t.h   = 11'(h);
    request_queue.insert(request_queue.size(), t);
  endtask

  // Skew toward small rectangles so shelves get shared, with edge sizes mixed in.
  function automatic int pick_side();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      case ($urandom_range(0, 5))
        0:       return 0;
        1:       return 1;
        2:       return PAGE_SIZE_DEF - 1;
        3:       return PAGE_SIZE_DEF;
        4:       return PAGE_SIZE_DEF + 1;
        default: return 2047;
      endcase
    end
    if (r < 40) return $urandom_range(1, 32);
    if (r < 75) return $urandom_range(1, 256);
    return $urandom_range(1, PAGE_SIZE_DEF);
  endfunction

  // Hold until the sender is drained and every allocation is back, then let a full scan pass.
  task automatic wait_idle();
    do @(negedge clk);
    while (request_queue.size() != 0 || s_axis_tvalid || expected_allocs.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_page_limit(logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    limit_mirror = v;
  endtask

  // Queue one phase of sequences: mostly clear-then-place runs, some shelf-table
  // fills with wide strips, and a little raw noise.
  task automatic fill_phase(bit keep_pages);
    int start_len, n, kind;
    bit first;
    start_len = request_queue.size();
    first     = 1'b1;
    while (request_queue.size() - start_len < PHASE_REQS) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        if (!(first && keep_pages))
          push_req(ACT_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));
        n = $urandom_range(4, 40);
        repeat (n) push_req(ACT_PLACE, pick_side(), pick_side());
      end else if (kind < 80) begin
        // Strips wider than half a page never share a shelf, so each opens one
        // until the shelf table is full and the scan spills to the next page.
        push_req(ACT_CLEAR, $urandom_range(0, 2047), $urandom_range(0, 2047));
        n = $urandom_range(60, 75);
        repeat (n)
          push_req(ACT_PLACE, $urandom_range(PAGE_SIZE_DEF / 2 + 1, PAGE_SIZE_DEF),
                   $urandom_range(1, 3));
      end else begin
        n = $urandom_range(5, 20);
        repeat (n)
          push_req($urandom_range(0, 1) ? ACT_CLEAR : ACT_PLACE, $urandom_range(0, 2047),
                   $urandom_range(0, 2047));
      end
      first = 1'b0;
    end
  endtask

  initial begin
    logic [LIMIT_W-1:0] limit_plan[PHASES];
    int ph;
    limit_plan = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd2, 4'd12, 4'd5};

    // Directed opening with the reset page limit and no idling.
    push_req(ACT_CLEAR, 2047, 2047);                         // clear ignores its fields
    push_req(ACT_PLACE, 0, 5);                               // zero width
    push_req(ACT_PLACE, 5, 0);                               // zero height
    push_req(ACT_PLACE, PAGE_SIZE_DEF + 1, 5);               // too wide
    push_req(ACT_PLACE, 5, PAGE_SIZE_DEF + 1);               // too tall
    push_req(ACT_PLACE, 2047, 2047);
    push_req(ACT_PLACE, PAGE_SIZE_DEF, PAGE_SIZE_DEF);       // fills page 0 exactly
    push_req(ACT_PLACE, 1, 1);                               // spills to a new page
    push_req(ACT_PLACE, PAGE_SIZE_DEF - 1, 10);              // taller: new shelf
    push_req(ACT_PLACE, 1, 5);                               // last column of that shelf
    push_req(ACT_PLACE, 1, 1);                               // back on the first shelf
    push_req(ACT_PLACE, PAGE_SIZE_DEF, PAGE_SIZE_DEF - 11);  // shelf ends at page bottom
    push_req(ACT_PLACE, PAGE_SIZE_DEF / 2, PAGE_SIZE_DEF);   // needs a third page
    push_req(ACT_PLACE, PAGE_SIZE_DEF / 2, PAGE_SIZE_DEF);   // shares its shelf
    push_req(ACT_PLACE, 1, 1);
    push_req(ACT_PLACE, PAGE_SIZE_DEF, PAGE_SIZE_DEF);       // fourth page
    push_req(ACT_PLACE, 7, 9);
    wait_idle();

    // Random phases. The first one lowers the limit below the pages still open.
    for (ph = 0; ph < PHASES; ph++) begin
      case (ph % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      write_page_limit(limit_plan[ph]);
      fill_phase(ph == 0);
      wait_idle();
    end

    // Anything still owed at this point is a failure.
    if (expected_allocs.size() != 0) begin
      fault_count += expected_allocs.size();
      $display("%0d allocations never arrived", expected_allocs.size());
    end
    if (fault_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // Hold reset from the start, then release it for good.
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

endmodule
